// File: rtl/ctcr_pkg.sv
// Shared constants, curve coefficients and interpolation tables for the color temperature converter.
`timescale 1ns / 1ps
package ctcr_pkg;

  localparam int Q              = 30;
  localparam int SEGS           = 256;
  localparam int LEVEL_BITS_DEF = 16;

  localparam logic [15:0] T_MIN      = 16'd1000;
  localparam logic [15:0] T_MAX      = 16'd40000;
  localparam logic [15:0] T_KNEE     = 16'd6600;
  localparam logic [15:0] T_BLUE_LO  = 16'd1900;
  localparam logic [15:0] T_HI_OFS   = 16'd6000;
  localparam logic [15:0] T_BLUE_OFS = 16'd1000;

  localparam logic [28:0] G1_LOG2 = 29'd290322552;
  localparam logic [30:0] G0      = 31'd678434584;
  localparam logic [28:0] B1_LOG2 = 29'd404287692;
  localparam logic [30:0] B0      = 31'd1284468048;
  localparam logic [30:0] RED_C   = 31'd1388279659;
  localparam logic [27:0] RED_A   = 28'd143027521;
  localparam logic [30:0] GRN_C   = 31'd1213211074;
  localparam logic [27:0] GRN_A   = 28'd81083452;

  localparam logic [30:0] ONE = 31'h4000_0000;

  typedef logic [31:0] rom_t [0:SEGS];

  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic rom_t build_log2_rom();
    rom_t        rom;
    logic [63:0] v;
    logic [63:0] res;
    for (int i = 0; i <= SEGS; i++) begin
      v   = 64'(SEGS + i) << 22;
      res = 64'd0;
      if (v >= (64'd2 << Q)) begin
        v   = v >> 1;
        res = 64'd1 << Q;
      end
      for (int k = 1; k <= Q; k++) begin
        v = (v * v) >> Q;
        if (v >= (64'd2 << Q)) begin
          v   = v >> 1;
          res = res + (64'd1 << (Q - k));
        end
      end
      rom[i] = res[31:0];
    end
    return rom;
  endfunction

  function automatic rom_t build_exp2_rom();
    rom_t        rom;
    logic [63:0] roots [0:8];
    logic [63:0] p;
    roots[0] = 64'd2 << Q;
    for (int k = 1; k <= 8; k++) roots[k] = isqrt64(roots[k-1] << Q);
    for (int i = 0; i < SEGS; i++) begin
      p = 64'd1 << Q;
      for (int k = 0; k < 8; k++) begin
        if (((i >> k) & 1) != 0) p = (p * roots[8-k]) >> Q;
      end
      rom[i] = p[31:0];
    end
    rom[SEGS] = 32'h8000_0000;
    return rom;
  endfunction

  localparam rom_t LOG2_ROM = build_log2_rom();
  localparam rom_t EXP2_ROM = build_exp2_rom();

  // log2(100): leading one at bit 6, table index 144, no remainder
  localparam logic [33:0] LOG2_100 = (34'd6 << Q) + 34'(LOG2_ROM[144]);

  typedef struct packed {
    logic hi;
    logic bone;
    logic bzero;
  } flags_t;

endpackage

// File: rtl/ctcr_log2.sv
// Two-stage log2(x/100) unit: normalize and table fetch, then interpolate.
`timescale 1ns / 1ps
module ctcr_log2 import ctcr_pkg::*; (
  input  logic        clk,
  input  logic        en1,
  input  logic        en2,
  input  logic [15:0] arg,
  output logic [33:0] lg
);

  logic [3:0]  e_nxt, e_r;
  logic [15:0] n;
  logic [8:0]  idx;
  logic [8:0]  idx1;
  logic [31:0] lo_r, hi_r;
  logic [6:0]  rem_r;
  logic [31:0] diff;
  logic [53:0] prod;
  logic [33:0] full;
  logic [33:0] lg_r;

  always_comb begin
    e_nxt = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (arg[i]) e_nxt = 4'(i);
    end
    n    = arg << (4'd15 - e_nxt);
    idx  = {1'b0, n[14:7]};
    idx1 = idx + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      e_r   <= e_nxt;
      lo_r  <= LOG2_ROM[idx];
      hi_r  <= LOG2_ROM[idx1];
      rem_r <= n[6:0];
    end
  end

  always_comb begin
    diff = hi_r - lo_r;
    prod = 54'(diff) * 54'({rem_r, 15'd0});
    full = {e_r, 30'd0} + 34'(lo_r) + 34'(prod[53:22]);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      lg_r <= (full > LOG2_100) ? full - LOG2_100 : 34'd0;
    end
  end

  assign lg = lg_r;

endmodule

// File: rtl/ctcr_exp2.sv
// Two-stage 2^-E unit: table fetch, then interpolate and shift by the integer part.
`timescale 1ns / 1ps
module ctcr_exp2 import ctcr_pkg::*; (
  input  logic        clk,
  input  logic        en1,
  input  logic        en2,
  input  logic [31:0] e_in,
  output logic [30:0] val
);

  logic [30:0] u;
  logic [8:0]  idx;
  logic [8:0]  idx1;
  logic [1:0]  k_r;
  logic [31:0] lo_r, hi_r;
  logic [21:0] rem_r;
  logic [31:0] diff;
  logic [53:0] prod;
  logic [31:0] v;
  logic [30:0] val_r;

  always_comb begin
    u    = ONE - {1'b0, e_in[29:0]};
    idx  = u[30:22];
    idx1 = idx + 9'd1;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      k_r <= e_in[31:30];
      if (idx >= 9'(SEGS)) begin
        lo_r  <= EXP2_ROM[SEGS];
        hi_r  <= EXP2_ROM[SEGS];
        rem_r <= 22'd0;
      end else begin
        lo_r  <= EXP2_ROM[idx];
        hi_r  <= EXP2_ROM[idx1];
        rem_r <= u[21:0];
      end
    end
  end

  always_comb begin
    diff = hi_r - lo_r;
    prod = 54'(diff) * 54'(rem_r);
    v    = lo_r + prod[53:22];
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      val_r <= 31'(v >> ({1'b0, k_r} + 3'd1));
    end
  end

  assign val = val_r;

endmodule

// File: rtl/color_temperature_to_rgb_unit.sv
// Top level: eight-stage color temperature to RGB level pipeline.
//   channel | ports                                   | dir
//   input   | in_valid in_stall in_temperature_kelvin | in
//   result  | out_valid out_stall out_{red,green,blue}_level | out
// One transfer per cycle sustained while out_stall is low.
// Stages: clamp, two log2 stages, coefficient products, two 2^-E stages,
// scale products, clamp and level scaling into the output register.
// Reset clears only the stage valid bits. A stall holds each occupied stage;
// empty stages keep filling, so bubbles close up behind a stalled result.
`timescale 1ns / 1ps
module color_temperature_to_rgb_unit import ctcr_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_temperature_kelvin,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_red_level,
  output logic [15:0] out_green_level,
  output logic [15:0] out_blue_level
);

  localparam int NST = 8;
  localparam logic [LEVEL_BITS-1:0] FULL = {LEVEL_BITS{1'b1}};

  logic [NST-1:0] v_r;
  logic [NST:0]   en;
  flags_t         fl_r [0:NST-2];

  logic [15:0] x;
  logic [15:0] a_r, b_r;
  logic [33:0] la, lb;

  logic [61:0] er_p, eg_p, g1_p, b1_p;
  logic [31:0] er_r, eg_r;
  logic signed [35:0] glo_r [3:6];
  logic signed [35:0] blo_r [3:6];
  logic [30:0] vr, vg;
  logic [61:0] rc_p, gc_p;
  logic [31:0] rhi_r, ghi_r;

  logic signed [35:0] rs, gs, bs;
  logic [30:0] rc, gc, bc;
  logic [15:0] red_r, green_r, blue_r;

  function automatic logic [30:0] clamp_unit(input logic signed [35:0] s);
    if (s < 0) return 31'd0;
    if (s > 36'sd1073741824) return ONE;
    return s[30:0];
  endfunction

  function automatic logic [15:0] to_level(input logic [30:0] c);
    logic [31+LEVEL_BITS:0] p;
    p = (32'(c) * (LEVEL_BITS+1)'(FULL)) + (LEVEL_BITS+32)'(ONE >> 1);
    return 16'(p >> Q);
  endfunction

  always_comb begin
    en[NST] = !v_r[NST-1] || !out_stall;
    for (int i = NST - 1; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // stage 0: saturate and form log arguments
  always_comb begin
    x = in_temperature_kelvin;
    if (x < T_MIN) x = T_MIN;
    if (x > T_MAX) x = T_MAX;
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_r         <= (x > T_KNEE) ? x - T_HI_OFS : x;
      b_r         <= x - T_BLUE_OFS;
      fl_r[0].hi    <= x > T_KNEE;
      fl_r[0].bone  <= x >= T_KNEE;
      fl_r[0].bzero <= x <= T_BLUE_LO;
    end
    for (int i = 1; i < NST - 1; i++) begin
      if (en[i]) fl_r[i] <= fl_r[i-1];
    end
  end

  // stages 1-2
  ctcr_log2 u_log_a (.clk(clk), .en1(en[1]), .en2(en[2]), .arg(a_r), .lg(la));
  ctcr_log2 u_log_b (.clk(clk), .en1(en[1]), .en2(en[2]), .arg(b_r), .lg(lb));

  // stage 3: coefficient products
  always_comb begin
    er_p = 62'(RED_A) * 62'(la);
    eg_p = 62'(GRN_A) * 62'(la);
    g1_p = 62'(G1_LOG2) * 62'(la);
    b1_p = 62'(B1_LOG2) * 62'(lb);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      er_r     <= er_p[61:30];
      eg_r     <= eg_p[61:30];
      glo_r[3] <= $signed({4'd0, g1_p[61:30]}) - $signed({5'd0, G0});
      blo_r[3] <= $signed({4'd0, b1_p[61:30]}) - $signed({5'd0, B0});
    end
    for (int i = 4; i <= 6; i++) begin
      if (en[i]) begin
        glo_r[i] <= glo_r[i-1];
        blo_r[i] <= blo_r[i-1];
      end
    end
  end

  // stages 4-5
  ctcr_exp2 u_exp_r (.clk(clk), .en1(en[4]), .en2(en[5]), .e_in(er_r), .val(vr));
  ctcr_exp2 u_exp_g (.clk(clk), .en1(en[4]), .en2(en[5]), .e_in(eg_r), .val(vg));

  // stage 6: scale products
  always_comb begin
    rc_p = 62'(RED_C) * 62'(vr);
    gc_p = 62'(GRN_C) * 62'(vg);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      rhi_r <= rc_p[61:30];
      ghi_r <= gc_p[61:30];
    end
  end

  // stage 7: branch select, clamp, level scaling
  always_comb begin
    rs = fl_r[6].hi ? $signed({4'd0, rhi_r}) : $signed({5'd0, ONE});
    gs = fl_r[6].hi ? $signed({4'd0, ghi_r}) : glo_r[6];
    if (fl_r[6].bone)       bs = $signed({5'd0, ONE});
    else if (fl_r[6].bzero) bs = 36'sd0;
    else                    bs = blo_r[6];
    rc = clamp_unit(rs);
    gc = clamp_unit(gs);
    bc = clamp_unit(bs);
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      red_r   <= to_level(rc);
      green_r <= to_level(gc);
      blue_r  <= to_level(bc);
    end
  end

  assign out_red_level   = red_r;
  assign out_green_level = green_r;
  assign out_blue_level  = blue_r;

endmodule
